// ===== sv/fsp_pkg.sv =====
// shared types and constants for the fir sample filter
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int DATA_W    = 16;
  localparam int TAP_IDX_W = 6;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC_BITS = 15;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [TAP_IDX_W-1:0]     tap_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // control fanned out to every tap cell
  typedef struct packed {
    logic     shift_en;
    logic     load_en;
    tap_idx_t tap_index;
    sample_t  data_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/fsp_in_if.sv =====
// input request channel: mode, tap index and sample or coefficient
`timescale 1ns / 1ps
`default_nettype none

interface fsp_in_if;
  logic             valid;
  logic             ready;
  logic             mode;
  fsp_pkg::tap_idx_t tap_index;
  fsp_pkg::sample_t  data_value;

  modport source (output valid, output mode, output tap_index, output data_value,
                  input ready);
  modport sink   (input valid, input mode, input tap_index, input data_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/fsp_out_if.sv =====
// result request channel: filtered sample and saturation flag
`timescale 1ns / 1ps
`default_nettype none

interface fsp_out_if;
  logic             valid;
  logic             ready;
  fsp_pkg::sample_t filtered_sample;
  logic             saturated;

  modport source (output valid, output filtered_sample, output saturated,
                  input ready);
  modport sink   (input valid, input filtered_sample, input saturated,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/fsp_tap_cell.sv =====
// one tap cell: sample, coefficient, registered product and partial sum
`timescale 1ns / 1ps
`default_nettype none

module fsp_tap_cell #(
  parameter int TAP_NUM = 0,
  parameter int ACC_W   = 38
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fsp_pkg::cell_ctrl_t     ctrl,
  input  wire fsp_pkg::sample_t        x_in,
  input  wire logic signed [ACC_W-1:0] sum_in,
  output fsp_pkg::sample_t             x_out,
  output logic signed [ACC_W-1:0]      sum_out
);

  localparam int  IDX_RANGE   = 1 << fsp_pkg::TAP_IDX_W;
  localparam bit  ADDRESSABLE = (TAP_NUM < IDX_RANGE);
  localparam fsp_pkg::tap_idx_t MY_IDX = fsp_pkg::tap_idx_t'(TAP_NUM % IDX_RANGE);

  fsp_pkg::sample_t                    x_r;
  fsp_pkg::sample_t                    c_r;
  logic signed [fsp_pkg::PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]             sum_r;
  logic                                coef_we;

  assign coef_we = ADDRESSABLE && ctrl.load_en && (ctrl.tap_index == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      c_r <= '0;
    end else begin
      if (ctrl.shift_en) begin
        x_r <= x_in;
      end
      if (coef_we) begin
        c_r <= ctrl.data_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= c_r * x_r;
    sum_r  <= sum_in + {{(ACC_W-fsp_pkg::PROD_W){prod_r[fsp_pkg::PROD_W-1]}}, prod_r};
  end

  assign x_out   = x_r;
  assign sum_out = sum_r;

endmodule

`default_nettype wire

// ===== sv/fsp_sat_stage.sv =====
// scale by 2^-15 toward zero and clip to int16
`timescale 1ns / 1ps
`default_nettype none

module fsp_sat_stage #(
  parameter int ACC_W = 38
) (
  input  wire logic signed [ACC_W-1:0] acc,
  output fsp_pkg::sample_t             filtered_sample,
  output logic                         saturated
);

  localparam int SUM_W = ACC_W + 1;
  localparam int Q_W   = SUM_W - fsp_pkg::FRAC_BITS;

  logic signed [SUM_W-1:0] biased;
  logic signed [Q_W-1:0]   quot;
  logic signed [Q_W-1:0]   max_q;
  logic signed [Q_W-1:0]   min_q;

  assign max_q = Q_W'(32767);
  assign min_q = -Q_W'(32768);

  // bias negatives so the arithmetic shift truncates toward zero
  assign biased = {acc[ACC_W-1], acc}
                + (acc[ACC_W-1] ? SUM_W'((1 << fsp_pkg::FRAC_BITS) - 1) : '0);
  assign quot   = Q_W'(biased >>> fsp_pkg::FRAC_BITS);

  always_comb begin
    if (quot > max_q) begin
      filtered_sample = fsp_pkg::sample_t'(16'sh7fff);
      saturated       = 1'b1;
    end else if (quot < min_q) begin
      filtered_sample = fsp_pkg::sample_t'(16'sh8000);
      saturated       = 1'b1;
    end else begin
      filtered_sample = quot[fsp_pkg::DATA_W-1:0];
      saturated       = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fir_filter_sample_top.sv =====
// a sample request shifts the delay line; its partial sum then ripples through the
// registered product and adder chain of the tap cells, and no new request is taken
// until the result is captured; coefficient loads are taken only while idle
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low, clears delay line, coefficients and control
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_sample_top #(
  parameter int TAPS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fsp_in_if.sink     in_ch,
  fsp_out_if.source  out_ch
);

  localparam int ACC_W = fsp_pkg::PROD_W + $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 2);

  fsp_pkg::state_t          state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r;
  fsp_pkg::sample_t         out_sample_r;
  logic                     out_sat_r;

  fsp_pkg::cell_ctrl_t      ctrl;
  fsp_pkg::sample_t         x_chain   [TAPS+1];
  logic signed [ACC_W-1:0]  sum_chain [TAPS+1];
  fsp_pkg::sample_t         sat_sample;
  logic                     sat_flag;

  logic in_fire, sample_acc, load_acc, out_free, load_out;

  assign in_ch.ready = (state_r == fsp_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sample_acc  = in_fire && (in_ch.mode == fsp_pkg::MODE_FILTER);
  assign load_acc    = in_fire && (in_ch.mode == fsp_pkg::MODE_LOAD);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == fsp_pkg::ST_RUN) && (cnt_r == '0) && out_free;

  assign ctrl.shift_en   = sample_acc;
  assign ctrl.load_en    = load_acc;
  assign ctrl.tap_index  = in_ch.tap_index;
  assign ctrl.data_value = in_ch.data_value;

  assign x_chain[0]   = in_ch.data_value;
  assign sum_chain[0] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fsp_tap_cell #(
      .TAP_NUM (k),
      .ACC_W   (ACC_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .x_in    (x_chain[k]),
      .sum_in  (sum_chain[k]),
      .x_out   (x_chain[k+1]),
      .sum_out (sum_chain[k+1])
    );
  end

  fsp_sat_stage #(
    .ACC_W (ACC_W)
  ) u_sat (
    .acc             (sum_chain[TAPS]),
    .filtered_sample (sat_sample),
    .saturated       (sat_flag)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      fsp_pkg::ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = fsp_pkg::ST_RUN;
          cnt_nxt   = CNT_W'(TAPS + 1);
        end
      end
      fsp_pkg::ST_RUN: begin
        if (load_out) begin
          state_nxt = fsp_pkg::ST_IDLE;
        end else if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = fsp_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsp_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= sat_sample;
      out_sat_r    <= sat_flag;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.filtered_sample = out_sample_r;
  assign out_ch.saturated       = out_sat_r;

  // sample request starts a full count
  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> (state_r == fsp_pkg::ST_RUN) && (cnt_r == CNT_W'(TAPS + 1)))
    else $error("sample request did not start the sum count");

  // coefficient load never starts a sum
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (state_r == fsp_pkg::ST_IDLE))
    else $error("coefficient load left idle");

  // result capture returns to idle with a valid result
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (state_r == fsp_pkg::ST_IDLE) && out_valid_r)
    else $error("result capture failed");

  // clipping flag only with an extreme output value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_sample_r == fsp_pkg::sample_t'(16'sh7fff)) ||
      (out_sample_r == fsp_pkg::sample_t'(16'sh8000)))
    else $error("saturation flag with non-extreme value");

endmodule

`default_nettype wire

// ===== bench/fir_filter_sample_top_tb.sv =====
// testbench for the fir sample filter: queued requests, in-order result check
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_sample_top_tb;

  localparam int TAPS = 64;
  localparam int RAND_REQUESTS = 750;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_AT = 420;

  typedef struct {
    logic              mode;
    fsp_pkg::tap_idx_t tap_index;
    fsp_pkg::sample_t  data_value;
    int                gap;
    bit                drain;
  } fir_request_t;

  typedef struct {
    fsp_pkg::sample_t filtered_sample;
    logic             saturated;
  } fir_result_t;

  logic clk;
  logic rst_n;

  fsp_in_if  in_if();
  fsp_out_if out_if();

  fir_filter_sample_top #(.TAPS(TAPS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  fir_request_t request_q[$];
  fir_result_t  filtered_q[$];

  fsp_pkg::sample_t coef_mem [TAPS];
  fsp_pkg::sample_t sample_hist [TAPS];
  int      hist_head;
  int      errors;

  fir_request_t cur_req;
  bit           have_cur;
  int           gap_left;
  int           hold_left;
  int           result_count;
  bit           out_quiet;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic fsp_pkg::sample_t pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 16'sh7fff;
      1: pick_value = 16'sh8000;
      2: pick_value = fsp_pkg::sample_t'($signed($urandom_range(0, 511)) - 256);
      3: pick_value = $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
      default: pick_value = fsp_pkg::sample_t'($urandom) >>> $urandom_range(0, 15);
    endcase
  endfunction

  // advance the filter state for one accepted request
  function automatic void apply_request(fir_request_t req);
    longint      acc;
    longint      mag;
    fir_result_t res;
    if (req.mode == fsp_pkg::MODE_LOAD) begin
      if (int'(req.tap_index) < TAPS) coef_mem[req.tap_index] = req.data_value;
      return;
    end
    hist_head = (hist_head + 1) % TAPS;
    sample_hist[hist_head] = req.data_value;
    acc = 0;
    for (int i = 0; i < TAPS; i++)
      acc += longint'(coef_mem[i]) * longint'(sample_hist[(hist_head + TAPS - i) % TAPS]);
    res.saturated = 1'b0;
    if (acc < 0) begin
      mag = (-acc) >> 15;
      if (mag > 32768) begin
        res.filtered_sample = 16'sh8000;
        res.saturated = 1'b1;
      end else begin
        res.filtered_sample = fsp_pkg::sample_t'(-mag);
      end
    end else begin
      mag = acc >> 15;
      if (mag > 32767) begin
        res.filtered_sample = 16'sh7fff;
        res.saturated = 1'b1;
      end else begin
        res.filtered_sample = fsp_pkg::sample_t'(mag);
      end
    end
    filtered_q.push_back(res);
  endfunction

  task automatic queue_request(logic mode, fsp_pkg::tap_idx_t tap, fsp_pkg::sample_t value,
                               int gap, bit drain);
    fir_request_t req;
    req.mode = mode;
    req.tap_index = tap;
    req.data_value = value;
    req.gap = gap;
    req.drain = drain;
    request_q.push_back(req);
  endtask

  task automatic queue_load(fsp_pkg::tap_idx_t tap, fsp_pkg::sample_t value);
    queue_request(fsp_pkg::MODE_LOAD, tap, value, $urandom_range(0, 12), 1'b0);
  endtask

  task automatic queue_sample(fsp_pkg::sample_t value);
    queue_request(fsp_pkg::MODE_FILTER, fsp_pkg::tap_idx_t'($urandom), value,
                  $urandom_range(0, 12), 1'b0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      have_cur = 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_request(cur_req);
        have_cur = 1'b0;
      end
      if (!have_cur && request_q.size() > 0 &&
          !(request_q[0].drain && filtered_q.size() > 0)) begin
        cur_req = request_q.pop_front();
        have_cur = 1'b1;
        gap_left = cur_req.gap;
      end
      if (have_cur && gap_left == 0) begin
        in_if.valid      <= 1'b1;
        in_if.mode       <= cur_req.mode;
        in_if.tap_index  <= cur_req.tap_index;
        in_if.data_value <= cur_req.data_value;
      end else begin
        in_if.valid <= 1'b0;
        if (have_cur) gap_left--;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      result_count = 0;
      out_quiet = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result sample=%0d sat=%0b", $time,
                   out_if.filtered_sample, out_if.saturated);
          errors++;
        end else begin
          fir_result_t exp_res;
          exp_res = filtered_q.pop_front();
          if (out_if.filtered_sample !== exp_res.filtered_sample) begin
            $display("%0t: filtered_sample expected %0d actual %0d", $time,
                     exp_res.filtered_sample, out_if.filtered_sample);
            errors++;
          end
          if (out_if.saturated !== exp_res.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     exp_res.saturated, out_if.saturated);
            errors++;
          end
        end
        result_count++;
        if (result_count % 40 == 0) out_quiet = ($urandom_range(0, 2) == 0);
        hold_left = out_quiet ? 0 : $urandom_range(0, 12);
        if (result_count == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_if.ready <= (hold_left == 0);
    end
  end

  initial begin
    bit quiet;
    int gap;
    rst_n = 1'b0;
    errors = 0;
    hist_head = 0;
    for (int i = 0; i < TAPS; i++) begin
      coef_mem[i] = '0;
      sample_hist[i] = '0;
    end
    in_if.valid = 1'b0;
    in_if.mode = fsp_pkg::MODE_FILTER;
    in_if.tap_index = '0;
    in_if.data_value = '0;
    out_if.ready = 1'b0;

    // zero taps give zero output
    queue_sample(16'sd100);
    // single full-scale tap: positive overflow, then a non-saturating extreme
    queue_load(6'd0, 16'sh8000);
    queue_sample(16'sh8000);
    queue_sample(16'sh7fff);
    queue_load(6'd63, 16'sh7fff);
    queue_load(6'd1, 16'sh7fff);
    queue_sample(16'sh8000);
    // negative overflow
    queue_load(6'd0, 16'sh7fff);
    queue_sample(16'sh8000);
    queue_sample(16'sh0000);
    // truncation toward zero of a tiny negative sum
    queue_load(6'd1, 16'sh0000);
    queue_load(6'd63, 16'sh0000);
    queue_load(6'd0, 16'sh0001);
    queue_sample(16'shffff);
    queue_sample(16'sh0000);
    queue_sample(16'sh7fff);
    queue_load(6'd42, 16'shffff);
    queue_load(6'd21, 16'sh5555);
    queue_sample(16'shaaaa);
    queue_sample(16'sh5555);

    quiet = 1'b0;
    for (int n = 0; n < RAND_REQUESTS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      gap = quiet ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0)
        queue_request(fsp_pkg::MODE_LOAD, fsp_pkg::tap_idx_t'($urandom), pick_value(),
                      gap, n == DRAIN_AT);
      else
        queue_request(fsp_pkg::MODE_FILTER, fsp_pkg::tap_idx_t'($urandom), pick_value(),
                      gap, n == DRAIN_AT);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || have_cur || filtered_q.size() > 0) @(posedge clk);
    repeat (TAPS + 8) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
